FILE: rtl/tle_pkg.sv
// shared types, character codes and redraw sequences for the terminal line editor
package tle_pkg;

    localparam logic [7:0] CH_BEL  = 8'd7;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [6:0] CH_SP   = 7'd32;
    localparam logic [7:0] CH_PMIN = 8'd32;
    localparam logic [7:0] CH_PMAX = 8'd126;

    localparam logic [1:0] CFG_EOF    = 2'd0;
    localparam logic [1:0] CFG_ERASE  = 2'd1;
    localparam logic [1:0] CFG_KILL   = 2'd2;
    localparam logic [1:0] CFG_WERASE = 2'd3;

    typedef enum logic [2:0] {
        CL_WERASE,
        CL_ERASE,
        CL_KILL,
        CL_NL,
        CL_PRINT,
        CL_OTHER
    } t_cls;

    typedef struct packed {
        logic [7:0] key;
        logic       eof_hit;
        t_cls       cls;
    } t_cmd;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_PRE,
        B_LINE,
        B_POST,
        B_CHAR,
        B_STAT
    } t_bstate;

    typedef enum logic [1:0] {
        SQ_REDRAW,
        SQ_KILL,
        SQ_SUBMIT
    } t_seq;

    function automatic logic [7:0] seq_byte(input t_seq s, input logic [2:0] k);
        logic [7:0] b;
        b = CH_CR;
        if (s == SQ_SUBMIT) begin
            b = CH_LF;
        end else begin
            unique case (k)
                3'd0:    b = CH_CR;
                3'd1:    b = CH_ESC;
                3'd2:    b = CH_LBR;
                3'd3:    b = CH_K;
                default: b = CH_CR;
            endcase
        end
        return b;
    endfunction

    function automatic logic [2:0] seq_last(input t_seq s);
        logic [2:0] n;
        unique case (s)
            SQ_REDRAW: n = 3'd3;
            SQ_KILL:   n = 3'd4;
            SQ_SUBMIT: n = 3'd0;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic seq_line(input t_seq s);
        return (s == SQ_REDRAW) || (s == SQ_SUBMIT);
    endfunction

    function automatic logic seq_post(input t_seq s);
        return s == SQ_SUBMIT;
    endfunction

endpackage

FILE: rtl/tle_front.sv
// front end: control character registers, key acceptance and classification
module tle_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_key_byte,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [7:0]       i_cfg_data,
    output logic             o_push,
    output tle_pkg::t_cmd    o_cmd,
    input  logic             i_full
);
    import tle_pkg::*;

    logic [7:0] r_eof;
    logic [7:0] r_erase;
    logic [7:0] r_kill;
    logic [7:0] r_werase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof    <= 8'd4;
            r_erase  <= 8'd127;
            r_kill   <= 8'd21;
            r_werase <= 8'd23;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EOF:    r_eof    <= i_cfg_data;
                CFG_ERASE:  r_erase  <= i_cfg_data;
                CFG_KILL:   r_kill   <= i_cfg_data;
                CFG_WERASE: r_werase <= i_cfg_data;
                default:    r_eof    <= r_eof;
            endcase
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.key     = i_key_byte;
        o_cmd.eof_hit = (i_key_byte == r_eof);
        if (i_key_byte == r_werase) begin
            o_cmd.cls = CL_WERASE;
        end else if (i_key_byte == r_erase) begin
            o_cmd.cls = CL_ERASE;
        end else if (i_key_byte == r_kill) begin
            o_cmd.cls = CL_KILL;
        end else if ((i_key_byte == CH_LF) || (i_key_byte == CH_CR)) begin
            o_cmd.cls = CL_NL;
        end else if ((i_key_byte >= CH_PMIN) && (i_key_byte <= CH_PMAX)) begin
            o_cmd.cls = CL_PRINT;
        end else begin
            o_cmd.cls = CL_OTHER;
        end
    end

endmodule

FILE: rtl/tle_queue.sv
// two-entry queue of classified keys between front and back
module tle_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tle_pkg::t_cmd    i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output tle_pkg::t_cmd    o_cmd,
    input  logic             i_pop
);
    import tle_pkg::*;

    t_cmd       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_ent[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

endmodule

FILE: rtl/tle_back.sv
// back end: line store, cursor, word scan and terminal byte sequencer
module tle_back #(
    parameter int LINE_MAX = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tle_pkg::t_cmd    i_q_cmd,
    output logic             o_q_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_session_end,
    output logic             o_last_of_run
);
    import tle_pkg::*;

    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam logic [CW-1:0] LMAX = CW'(LINE_MAX);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_bstate       r_state;
    t_bstate       n_state;
    logic [CW-1:0] r_cursor;
    logic [CW-1:0] n_cursor;
    logic          r_ended;
    logic          n_ended;
    logic [CW-1:0] r_p;
    logic [CW-1:0] n_p;
    logic          r_wph;
    logic          n_wph;
    t_seq          r_seq;
    t_seq          n_seq;
    logic [2:0]    r_k;
    logic [2:0]    n_k;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] n_idx;
    logic [AW-1:0] r_ra;
    logic [AW-1:0] n_ra;
    logic [6:0]    r_rd;
    logic [7:0]    r_chr;
    logic [7:0]    n_chr;
    logic          r_sub;
    logic          n_sub;

    logic          r_ovalid;
    logic [7:0]    r_obyte;
    logic          r_ohas;
    logic          r_oend;
    logic          r_olast;

    logic [6:0]    r_mem [LINE_MAX];
    logic          w_we;
    logic [AW-1:0] w_wa;

    logic          w_free;
    logic          w_emit;
    logic [7:0]    e_byte;
    logic          e_has;
    logic          e_end;
    logic          e_last;
    logic          w_scan_done;
    logic          w_pre_end;
    logic          w_line_end;
    logic          w_to_line;
    logic [CW-1:0] w_cm1;

    assign w_free      = !r_ovalid || !i_stall;
    assign o_q_pop     = (r_state == B_IDLE) && i_q_valid;
    assign w_cm1       = r_cursor - ONE;
    assign w_scan_done = (r_p == '0) || (r_wph && (r_rd == CH_SP));
    assign w_pre_end   = (r_k == seq_last(r_seq));
    assign w_to_line   = seq_line(r_seq) && (r_cursor != '0);
    assign w_line_end  = (CW'(r_idx) == w_cm1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid && !r_ended) begin
                    if (i_q_cmd.eof_hit && (r_cursor == '0)) begin
                        n_state = B_STAT;
                    end else begin
                        case (i_q_cmd.cls) inside
                            CL_WERASE:            n_state = B_SCAN;
                            CL_ERASE:             n_state = (r_cursor != '0) ? B_PRE : B_IDLE;
                            CL_KILL, CL_NL:       n_state = B_PRE;
                            default:              n_state = B_CHAR;
                        endcase
                    end
                end
            end
            B_SCAN: begin
                if (w_scan_done) begin
                    n_state = B_PRE;
                end
            end
            B_PRE: begin
                if (w_free && w_pre_end) begin
                    if (w_to_line) begin
                        n_state = B_LINE;
                    end else if (seq_post(r_seq)) begin
                        n_state = B_POST;
                    end else begin
                        n_state = B_IDLE;
                    end
                end
            end
            B_LINE: begin
                if (w_free && w_line_end) begin
                    n_state = seq_post(r_seq) ? B_POST : B_IDLE;
                end
            end
            B_CHAR: begin
                if (w_free) begin
                    n_state = r_sub ? B_PRE : B_IDLE;
                end
            end
            B_POST, B_STAT: begin
                if (w_free) begin
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // datapath and emitted bytes
    always_comb begin
        n_cursor = r_cursor;
        n_ended  = r_ended;
        n_p      = r_p;
        n_wph    = r_wph;
        n_seq    = r_seq;
        n_k      = r_k;
        n_idx    = r_idx;
        n_ra     = r_ra;
        n_chr    = r_chr;
        n_sub    = r_sub;
        w_we     = 1'b0;
        w_wa     = AW'(r_cursor);
        w_emit   = 1'b0;
        e_byte   = 8'd0;
        e_has    = 1'b1;
        e_end    = 1'b0;
        e_last   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (i_q_valid && !r_ended) begin
                    n_k   = 3'd0;
                    n_idx = '0;
                    n_ra  = '0;
                    n_sub = 1'b0;
                    n_chr = CH_BEL;
                    if (i_q_cmd.eof_hit && (r_cursor == '0)) begin
                        n_ended = 1'b1;
                    end else begin
                        case (i_q_cmd.cls)
                            CL_WERASE: begin
                                n_p   = r_cursor;
                                n_wph = 1'b0;
                                n_seq = SQ_REDRAW;
                                n_ra  = (r_cursor == '0) ? '0 : AW'(w_cm1);
                            end
                            CL_ERASE: begin
                                n_seq = SQ_REDRAW;
                                if (r_cursor != '0) begin
                                    n_cursor = w_cm1;
                                end
                            end
                            CL_KILL: begin
                                n_seq    = SQ_KILL;
                                n_cursor = '0;
                            end
                            CL_NL: begin
                                n_seq = SQ_SUBMIT;
                            end
                            CL_PRINT: begin
                                w_we     = 1'b1;
                                n_chr    = i_q_cmd.key;
                                n_cursor = r_cursor + ONE;
                                n_sub    = ((r_cursor + ONE) == LMAX);
                                n_seq    = SQ_SUBMIT;
                            end
                            default: begin
                                n_chr = CH_BEL;
                            end
                        endcase
                    end
                end
            end
            B_SCAN: begin
                if (w_scan_done) begin
                    n_cursor = ((r_p == '0) && !r_wph) ? r_cursor : r_p;
                    n_ra     = '0;
                end else begin
                    if (!r_wph && (r_rd != CH_SP)) begin
                        n_wph = 1'b1;
                    end else begin
                        n_p = r_p - ONE;
                    end
                    n_ra = (n_p == '0) ? '0 : AW'(n_p - ONE);
                end
            end
            B_PRE: begin
                w_emit = 1'b1;
                e_byte = seq_byte(r_seq, r_k);
                e_last = w_pre_end && !w_to_line && !seq_post(r_seq);
                if (w_free) begin
                    n_k = r_k + 3'd1;
                end
            end
            B_LINE: begin
                w_emit = 1'b1;
                e_byte = {1'b0, r_rd};
                e_last = w_line_end && !seq_post(r_seq);
                if (w_free && !w_line_end) begin
                    n_idx = r_idx + AW'(1);
                    n_ra  = r_idx + AW'(1);
                end
            end
            B_POST: begin
                w_emit = 1'b1;
                e_byte = CH_LF;
                e_last = 1'b1;
                if (w_free) begin
                    n_cursor = '0;
                end
            end
            B_CHAR: begin
                w_emit = 1'b1;
                e_byte = r_chr;
                e_last = !r_sub;
                if (w_free) begin
                    n_k = 3'd0;
                end
            end
            B_STAT: begin
                w_emit = 1'b1;
                e_has  = 1'b0;
                e_end  = 1'b1;
                e_last = 1'b1;
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_cursor <= '0;
            r_ended  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_ended  <= n_ended;
            if (w_free) begin
                r_ovalid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p   <= n_p;
        r_wph <= n_wph;
        r_seq <= n_seq;
        r_k   <= n_k;
        r_idx <= n_idx;
        r_ra  <= n_ra;
        r_chr <= n_chr;
        r_sub <= n_sub;
        if (w_free) begin
            r_obyte <= e_byte;
            r_ohas  <= e_has;
            r_oend  <= e_end;
            r_olast <= e_last;
        end
    end

    // line store, read every cycle at the next read address
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= i_q_cmd.key[6:0];
        end
        r_rd <= r_mem[n_ra];
    end

    assign o_valid       = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_has_byte    = r_ohas;
    assign o_session_end = r_oend;
    assign o_last_of_run = r_olast;

    a_end_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oend) |-> (r_olast && !r_ohas))
        else $error("session end item malformed");

    a_cursor_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= LMAX)
        else $error("cursor beyond line length");

    a_ended_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ended && (r_state == B_IDLE)) |=> (r_state == B_IDLE))
        else $error("work started after session end");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SCAN) |-> (r_p <= r_cursor))
        else $error("word scan past cursor");

endmodule

FILE: rtl/terminal_line_editor.sv
// top level of the terminal line editor
//
//  channel   direction  handshake           payload
//  key in    in         i_valid / o_stall   i_key_byte
//  term out  out        o_valid / i_stall   o_out_byte o_has_byte o_session_end o_last_of_run
//  config    in         i_cfg_we            i_cfg_idx i_cfg_data
//
//  a key is dispatched from the queue head while the back end is idle, then its bytes
//  leave at one per cycle from the output register while the output does not stall;
//  word erase first scans the line store, one entry per cycle; the two-entry queue
//  takes keys while the back end works
//  synchronous active-low reset; no clearing pass, the line store holds unwritten data
//  an output stall freezes the sequencer; the input stalls only when the queue is full
module terminal_line_editor #(
    parameter int LINE_MAX = 40
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_key_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_session_end,
    output logic       o_last_of_run,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import tle_pkg::*;

    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;
    t_cmd w_cmd_in;
    t_cmd w_cmd_out;

    tle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_key_byte (i_key_byte),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push),
        .o_cmd      (w_cmd_in),
        .i_full     (w_full)
    );

    tle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_cmd_out),
        .i_pop   (w_pop)
    );

    tle_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_cmd_out),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_has_byte    (o_has_byte),
        .o_session_end (o_session_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule
